FILE: design/fpexp_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point exponential package
// Widths, constants, the sideband type and the Q16.16 product scaling helper
// that the exponential pipeline shares between its modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fpexp_pkg;

  localparam int QFRAC = 16;
  localparam int XW    = 32;              // argument width
  localparam int EW    = 31;              // result width
  localparam int NW    = 6;               // power of two, fits -16..15 and more
  localparam int GW    = 18;              // reduced argument and its square
  localparam int PW    = 20;              // Horner partial sum
  localparam int RW    = 21;              // polynomial result before scaling
  localparam int PRODW = 50;              // widest product in the datapath
  localparam int QW    = PRODW - QFRAC;   // product after scaling down

  localparam logic signed [XW-1:0]  ARG_MAX = 32'sd681391;
  localparam logic signed [XW-1:0]  ARG_MIN = -32'sd726817;
  localparam logic signed [GW-1:0]  LOG2E_Q = 18'sd94548;
  localparam logic signed [GW-1:0]  LN2_HI  = 18'sd45440;
  localparam logic signed [GW-1:0]  LN2_LO  = -18'sd13;
  localparam logic signed [GW-1:0]  LN2_Q   = LN2_HI + LN2_LO;
  localparam logic signed [PW-1:0]  POLY_A1 = 20'sd13;
  localparam logic signed [PW-1:0]  POLY_A2 = 20'sd91;
  localparam logic signed [PW-1:0]  POLY_A3 = 20'sd546;
  localparam logic signed [PW-1:0]  POLY_A4 = 20'sd2730;
  localparam logic signed [PW-1:0]  POLY_A5 = 20'sd10922;
  localparam logic signed [PW-1:0]  POLY_A6 = 20'sd32768;
  localparam logic signed [QW-1:0]  Q_HALF  = 34'sd32768;
  localparam logic signed [RW-1:0]  Q_ONE   = 21'sd65536;
  localparam logic [EW-1:0]         SAT_MAX = 31'h7fffffff;

  // Control and operands that travel alongside the Horner partial sum.
  typedef struct packed {
    logic                 vld;
    logic                 hi;
    logic                 lo;
    logic signed [NW-1:0] n;
    logic signed [GW-1:0] g;
    logic signed [GW-1:0] g2;
  } side_t;

  // Divide a product by 2^16, rounding toward zero.
  function automatic logic signed [QW-1:0] qdiv(input logic signed [PRODW-1:0] a);
    logic signed [PRODW-1:0] b;
    b = a + (a[PRODW-1] ? PRODW'((1 << QFRAC) - 1) : PRODW'(0));
    return QW'(b >>> QFRAC);
  endfunction

endpackage

`default_nettype wire

FILE: design/fpexp_horner.sv
// ----------------------------------------------------------------------------
// Fixed-point exponential Horner stage
// One registered step p' = (p * g) / 2^16 + coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module fpexp_horner #(
  parameter logic signed [fpexp_pkg::PW-1:0] Coef = '0
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fpexp_pkg::side_t                  side_i,
  input  wire logic signed [fpexp_pkg::PW-1:0]   p_i,
  output fpexp_pkg::side_t                       side_o,
  output logic signed [fpexp_pkg::PW-1:0]        p_o
);

  fpexp_pkg::side_t                      side_q;
  logic signed [fpexp_pkg::PW-1:0]       p_d, p_q;
  logic signed [fpexp_pkg::PRODW-1:0]    prod;

  assign prod = fpexp_pkg::PRODW'(p_i) * fpexp_pkg::PRODW'(side_i.g);
  assign p_d  = fpexp_pkg::PW'(fpexp_pkg::qdiv(prod)) + Coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign side_o = side_q;
  assign p_o    = p_q;

endmodule

`default_nettype wire

FILE: design/fixed_point_exponential_top.sv
// ----------------------------------------------------------------------------
// Fixed-point exponential, top level
// Computes e^x for a signed Q16.16 argument and returns an unsigned Q15.16
// result, saturated at 0x7fffffff, through a ten-stage pipeline.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// command   in         start_i, busy_o       x_in_i     (32 bit, signed)
// result    out        out_valid_o (strobe)  exp_out_o  (31 bit, unsigned)
//
// A new beat is taken in every cycle: busy_o is always low, so a command beat
// is accepted at each rising edge with start_i high.
// Each result beat appears after its command beat, in
// order, and is shown for one cycle with out_valid_o high.
// The pipeline has ten register stages: range reduction (three),
// the squared argument with the first coefficient, four Horner steps, the
// final product and the power-of-two scaling.
// The receiver cannot stall, so nothing ever backs up into the pipeline.
// Reset clears every valid bit and the whole sideband of stages 3 to 8; other data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_exponential_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [fpexp_pkg::XW-1:0]   x_in_i,
  output logic                                   out_valid_o,
  output logic [fpexp_pkg::EW-1:0]               exp_out_o
);

  localparam int Latency = 10;

  // Stage 1: range checks and the product x * log2(e).
  logic                                  v1_q, hi1_q, lo1_q;
  logic signed [fpexp_pkg::XW-1:0]       x1_q;
  logic signed [fpexp_pkg::PRODW-1:0]    prod1_d, prod1_q;

  // Stage 2: the power of two n, rounded half up.
  logic                                  v2_q, hi2_q, lo2_q;
  logic signed [fpexp_pkg::XW-1:0]       x2_q;
  logic signed [fpexp_pkg::QW-1:0]       t2;
  logic signed [fpexp_pkg::NW-1:0]       n2_d, n2_q;

  // Stage 3: the reduced argument g = x - n * ln2.
  logic signed [fpexp_pkg::XW-1:0]       g3_full;
  fpexp_pkg::side_t                      side3_d, side3_q;

  // Stage 4: g squared and the first Horner step.
  fpexp_pkg::side_t                      side4_d, side4_q;
  logic signed [fpexp_pkg::PW-1:0]       p4_d, p4_q;

  // Stages 5 to 8: Horner steps.
  fpexp_pkg::side_t                      side5, side6, side7, side8;
  logic signed [fpexp_pkg::PW-1:0]       p5, p6, p7, p8;

  // Stage 9: r = p * g^2 + g + 1.
  logic                                  v9_q, hi9_q, lo9_q;
  logic signed [fpexp_pkg::NW-1:0]       n9_q;
  logic signed [fpexp_pkg::RW-1:0]       r9_d, r9_q;

  // Stage 10: scaling by 2^n and saturation.
  logic [50:0]                           up10;
  logic [fpexp_pkg::RW-2:0]              down10;
  logic [fpexp_pkg::NW-1:0]              neg10;
  logic [fpexp_pkg::EW-1:0]              exp_d, exp_q;
  logic                                  out_valid_q;

  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1
  // --------------------------------------------------------------------------
  assign prod1_d = fpexp_pkg::PRODW'(x_in_i) * fpexp_pkg::PRODW'(fpexp_pkg::LOG2E_Q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    hi1_q   <= x_in_i > fpexp_pkg::ARG_MAX;
    lo1_q   <= x_in_i < fpexp_pkg::ARG_MIN;
    x1_q    <= x_in_i;
    prod1_q <= prod1_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: floor((x * log2(e) + 1/2)) as an arithmetic shift.
  // --------------------------------------------------------------------------
  assign t2   = fpexp_pkg::qdiv(prod1_q) + fpexp_pkg::Q_HALF;
  assign n2_d = fpexp_pkg::NW'(t2 >>> fpexp_pkg::QFRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hi2_q <= hi1_q;
    lo2_q <= lo1_q;
    x2_q  <= x1_q;
    n2_q  <= n2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: both parts of ln2 are folded into one constant, which gives the
  // same sum exactly.
  // --------------------------------------------------------------------------
  assign g3_full = x2_q - fpexp_pkg::XW'(n2_q) * fpexp_pkg::XW'(fpexp_pkg::LN2_Q);

  always_comb begin
    side3_d     = '0;
    side3_d.vld = v2_q;
    side3_d.hi  = hi2_q;
    side3_d.lo  = lo2_q;
    side3_d.n   = n2_q;
    side3_d.g   = fpexp_pkg::GW'(g3_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side3_q <= '0;
    end else begin
      side3_q <= side3_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4
  // --------------------------------------------------------------------------
  always_comb begin
    side4_d    = side3_q;
    side4_d.g2 = fpexp_pkg::GW'(fpexp_pkg::qdiv(
                   fpexp_pkg::PRODW'(side3_q.g) * fpexp_pkg::PRODW'(side3_q.g)));
    p4_d       = fpexp_pkg::PW'(fpexp_pkg::qdiv(
                   fpexp_pkg::PRODW'(side3_q.g) * fpexp_pkg::PRODW'(fpexp_pkg::POLY_A1)))
                 + fpexp_pkg::POLY_A2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side4_q <= '0;
    end else begin
      side4_q <= side4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p4_q <= p4_d;
  end

  // --------------------------------------------------------------------------
  // Stages 5 to 8
  // --------------------------------------------------------------------------
  fpexp_horner #(.Coef(fpexp_pkg::POLY_A3)) u_horner_a3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side4_q),
    .p_i    (p4_q),
    .side_o (side5),
    .p_o    (p5)
  );

  fpexp_horner #(.Coef(fpexp_pkg::POLY_A4)) u_horner_a4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side5),
    .p_i    (p5),
    .side_o (side6),
    .p_o    (p6)
  );

  fpexp_horner #(.Coef(fpexp_pkg::POLY_A5)) u_horner_a5 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side6),
    .p_i    (p6),
    .side_o (side7),
    .p_o    (p7)
  );

  fpexp_horner #(.Coef(fpexp_pkg::POLY_A6)) u_horner_a6 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side7),
    .p_i    (p7),
    .side_o (side8),
    .p_o    (p8)
  );

  // --------------------------------------------------------------------------
  // Stage 9
  // --------------------------------------------------------------------------
  assign r9_d = fpexp_pkg::RW'(fpexp_pkg::qdiv(
                  fpexp_pkg::PRODW'(p8) * fpexp_pkg::PRODW'(side8.g2)))
                + fpexp_pkg::RW'(side8.g) + fpexp_pkg::Q_ONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else begin
      v9_q <= side8.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hi9_q <= side8.hi;
    lo9_q <= side8.lo;
    n9_q  <= side8.n;
    r9_q  <= r9_d;
  end

  // --------------------------------------------------------------------------
  // Stage 10: a left shift saturates when any bit would pass bit 30; a right
  // shift floors, which for a non-negative value is a plain shift.
  // --------------------------------------------------------------------------
  assign neg10  = -n9_q;
  assign up10   = 51'(r9_q[fpexp_pkg::RW-2:0]) << n9_q[4:0];
  assign down10 = r9_q[fpexp_pkg::RW-2:0] >> neg10;

  always_comb begin
    if (hi9_q) begin
      exp_d = fpexp_pkg::SAT_MAX;
    end else if (lo9_q || r9_q[fpexp_pkg::RW-1]) begin
      exp_d = '0;
    end else if (n9_q > 0) begin
      exp_d = (up10 > 51'(fpexp_pkg::SAT_MAX)) ? fpexp_pkg::SAT_MAX
                                                 : fpexp_pkg::EW'(up10);
    end else if (n9_q < 0) begin
      exp_d = fpexp_pkg::EW'(down10);
    end else begin
      exp_d = fpexp_pkg::EW'(r9_q[fpexp_pkg::RW-2:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
  end

  assign out_valid_o = out_valid_q;
  assign exp_out_o   = exp_q;

`ifndef SYNTHESIS
  // Every accepted beat comes out exactly after the pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency out_valid_o)
    else $error("result beat missing after accepted command");

  // No result beat without a command beat that caused it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("result beat without command");

  // Arguments above the upper limit saturate.
  a_sat_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (x_in_i > fpexp_pkg::ARG_MAX)
    |-> ##Latency (exp_out_o == fpexp_pkg::SAT_MAX))
    else $error("upper limit not saturated");

  // Arguments below the lower limit give zero.
  a_sat_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (x_in_i < fpexp_pkg::ARG_MIN)
    |-> ##Latency (exp_out_o == '0))
    else $error("lower limit not cleared");

  // Inside the limits the power of two stays within -16..15.
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side3_q.vld && !side3_q.hi && !side3_q.lo
    |-> (side3_q.n >= -6'sd16) && (side3_q.n <= 6'sd15))
    else $error("power of two out of range");
`endif

endmodule

`default_nettype wire
